@@ sv/tlfq_pkg.sv @@
`default_nettype none
package tlfq_pkg;

  localparam int DefQueueDepth = 16;
  localparam int NumLevels     = 3;

  localparam int ID_W    = 8;
  localparam int TIME_W  = 16;
  localparam int SLICE_W = 8;
  localparam int STAT_W  = 3;
  localparam int LVL_W   = 2;
  localparam int HELD_W  = 5;
  localparam int CIDX_W  = 2;
  localparam int ENTRY_W = ID_W + TIME_W;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [SLICE_W-1:0] slice_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [LVL_W-1:0]   level_t;

  // Action codes.
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Result status codes.
  localparam status_t ST_IDLE     = 3'd0;
  localparam status_t ST_RAN      = 3'd1;
  localparam status_t ST_FINISHED = 3'd2;
  localparam status_t ST_DEMOTED  = 3'd3;
  localparam status_t ST_KEPT     = 3'd4;
  localparam status_t ST_ADDED    = 3'd5;
  localparam status_t ST_REFUSED  = 3'd6;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_SLICE_ONE   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SLICE_TWO   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SLICE_THREE = 2'd2;

  localparam slice_t SLICE_ONE_RST   = 8'd5;
  localparam slice_t SLICE_TWO_RST   = 8'd6;
  localparam slice_t SLICE_THREE_RST = 8'd8;

endpackage
`default_nettype wire

@@ sv/three_level_feedback_queue_scheduler.sv @@
`default_nettype none
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_action, in_process_id, in_need_time
// out      output     out_valid/out_ready  out_status, out_served_id, out_served_level,
//                                          out_remaining_time, out_held_count
// cfg      input      cfg_we               cfg_index, cfg_wdata
//
// A tick that serves a level reads the head entry from the queue memory in the
// idle state and updates it in the execute state. An add, a refused add or an
// idle tick is done in the idle state alone.
// Reset is synchronous and clears all pointers, counts and run flags; the
// queue memory holds no reset value. While a result beat waits on out_ready,
// the block finishes at most the item already taken and then holds in_ready low.
module three_level_feedback_queue_scheduler #(
  parameter int QUEUE_DEPTH = tlfq_pkg::DefQueueDepth
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_action,
  input  wire tlfq_pkg::id_t           in_process_id,
  input  wire tlfq_pkg::time_t         in_need_time,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output tlfq_pkg::status_t            out_status,
  output tlfq_pkg::id_t                out_served_id,
  output tlfq_pkg::level_t             out_served_level,
  output tlfq_pkg::time_t              out_remaining_time,
  output logic [tlfq_pkg::HELD_W-1:0]  out_held_count,
  input  wire logic                    cfg_we,
  input  wire logic [tlfq_pkg::CIDX_W-1:0] cfg_index,
  input  wire tlfq_pkg::slice_t        cfg_wdata
);
  import tlfq_pkg::*;

  localparam int MEM_DEPTH = NumLevels * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam ptr_t  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam cnt_t  CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam addr_t QD_A     = ADDR_W'(QUEUE_DEPTH);

  function automatic addr_t slot_addr(input level_t lv, input ptr_t p);
    return addr_t'(lv) * QD_A + addr_t'(p);
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + ptr_t'(1);
  endfunction

  // Queue memory: {id, remaining} per entry.
  logic [ENTRY_W-1:0] mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we, mem_re;
  addr_t              mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic   state_r, state_nxt;
  ptr_t   head_r [NumLevels], head_nxt [NumLevels];
  ptr_t   tail_r [NumLevels], tail_nxt [NumLevels];
  cnt_t   lcnt_r [NumLevels], lcnt_nxt [NumLevels];
  slice_t left_r [NumLevels], left_nxt [NumLevels];
  logic   run_r  [NumLevels], run_nxt  [NumLevels];
  cnt_t   total_r, total_nxt;
  slice_t cfg_r  [NumLevels];
  level_t lv_r, lv_nxt;
  addr_t  hslot_r, hslot_nxt;

  logic    out_valid_r, out_load;
  status_t out_status_r, res_status;
  id_t     out_id_r, res_id;
  level_t  out_level_r, res_level;
  time_t   out_rem_r, res_rem;
  logic [HELD_W-1:0] out_held_r;
  logic [CNT_W+HELD_W-1:0] held_ext;

  logic   in_fire, sel_any;
  level_t sel_lv, nxt_lv;
  id_t    rd_id;
  time_t  rd_rem;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign rd_id    = rd_q[ENTRY_W-1:TIME_W];
  assign rd_rem   = rd_q[TIME_W-1:0];
  assign nxt_lv   = lv_r + level_t'(1);

  // Level selection for a tick, from the priority and run flags.
  always_comb begin
    sel_any = 1'b1;
    sel_lv  = 2'd0;
    if (lcnt_r[0] != '0 && !run_r[1] && !run_r[2]) begin
      sel_lv = 2'd0;
    end else if (lcnt_r[1] != '0 && !run_r[2]) begin
      sel_lv = 2'd1;
    end else if (lcnt_r[2] != '0) begin
      sel_lv = 2'd2;
    end else begin
      sel_any = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < NumLevels; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      lcnt_nxt[i] = lcnt_r[i];
      left_nxt[i] = left_r[i];
      run_nxt[i]  = run_r[i];
    end
    total_nxt  = total_r;
    state_nxt  = state_r;
    lv_nxt     = lv_r;
    hslot_nxt  = hslot_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = slot_addr(2'd0, tail_r[0]);
    mem_raddr  = slot_addr(sel_lv, head_r[sel_lv]);
    mem_wdata  = {in_process_id, in_need_time};
    out_load   = 1'b0;
    res_status = ST_IDLE;
    res_id     = '0;
    res_level  = '0;
    res_rem    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_ADD) begin
            out_load = 1'b1;
            res_id   = in_process_id;
            if (total_r == CNT_FULL) begin
              res_status = ST_REFUSED;
            end else begin
              mem_we      = 1'b1;
              tail_nxt[0] = ptr_inc(tail_r[0]);
              lcnt_nxt[0] = lcnt_r[0] + cnt_t'(1);
              total_nxt   = total_r + cnt_t'(1);
              res_status  = ST_ADDED;
              res_level   = 2'd1;
              res_rem     = in_need_time;
            end
          end else if (sel_any) begin
            mem_re    = 1'b1;
            lv_nxt    = sel_lv;
            hslot_nxt = mem_raddr;
            state_nxt = S_EXEC;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      S_EXEC: begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
        res_id    = rd_id;
        res_level = lv_r + level_t'(1);
        res_rem   = rd_rem;
        if (left_r[lv_r] == '0) begin
          left_nxt[lv_r] = cfg_r[lv_r];
          run_nxt[lv_r]  = 1'b0;
          if (lv_r != 2'd2) begin
            // Demote: pop here, push onto the tail of the next level.
            head_nxt[lv_r]   = ptr_inc(head_r[lv_r]);
            lcnt_nxt[lv_r]   = lcnt_r[lv_r] - cnt_t'(1);
            mem_we           = 1'b1;
            mem_waddr        = slot_addr(nxt_lv, tail_r[nxt_lv]);
            mem_wdata        = rd_q;
            tail_nxt[nxt_lv] = ptr_inc(tail_r[nxt_lv]);
            lcnt_nxt[nxt_lv] = lcnt_r[nxt_lv] + cnt_t'(1);
            res_status       = ST_DEMOTED;
          end else begin
            res_status = ST_KEPT;
          end
        end else if (rd_rem <= time_t'(1)) begin
          // A need of zero finishes on its first unit, like a need of one.
          left_nxt[lv_r] = cfg_r[lv_r];
          run_nxt[lv_r]  = 1'b0;
          head_nxt[lv_r] = ptr_inc(head_r[lv_r]);
          lcnt_nxt[lv_r] = lcnt_r[lv_r] - cnt_t'(1);
          total_nxt      = total_r - cnt_t'(1);
          res_status     = ST_FINISHED;
          res_rem        = '0;
        end else begin
          left_nxt[lv_r] = left_r[lv_r] - slice_t'(1);
          run_nxt[lv_r]  = 1'b1;
          mem_we         = 1'b1;
          mem_waddr      = hslot_r;
          mem_wdata      = {rd_id, rd_rem - time_t'(1)};
          res_status     = ST_RAN;
          res_rem        = rd_rem - time_t'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign held_ext = (CNT_W + HELD_W)'(total_nxt);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      lv_r        <= '0;
      cfg_r[0]    <= SLICE_ONE_RST;
      cfg_r[1]    <= SLICE_TWO_RST;
      cfg_r[2]    <= SLICE_THREE_RST;
      left_r[0]   <= SLICE_ONE_RST;
      left_r[1]   <= SLICE_TWO_RST;
      left_r[2]   <= SLICE_THREE_RST;
      for (int i = 0; i < NumLevels; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        lcnt_r[i] <= '0;
        run_r[i]  <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      lv_r    <= lv_nxt;
      for (int i = 0; i < NumLevels; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        lcnt_r[i] <= lcnt_nxt[i];
        left_r[i] <= left_nxt[i];
        run_r[i]  <= run_nxt[i];
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLICE_ONE:   cfg_r[0] <= cfg_wdata;
          CFG_SLICE_TWO:   cfg_r[1] <= cfg_wdata;
          CFG_SLICE_THREE: cfg_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hslot_r <= hslot_nxt;
    if (out_load) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_level_r  <= res_level;
      out_rem_r    <= res_rem;
      out_held_r   <= held_ext[HELD_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_served_id      = out_id_r;
  assign out_served_level   = out_level_r;
  assign out_remaining_time = out_rem_r;
  assign out_held_count     = out_held_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_FULL)
    else $error("held count exceeds queue depth");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 2)'(lcnt_r[0]) + (CNT_W + 2)'(lcnt_r[1]) + (CNT_W + 2)'(lcnt_r[2])
      == (CNT_W + 2)'(total_r))
    else $error("level counts disagree with held count");

  a_tick_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_TICK && sel_any) |=> (state_r == S_EXEC && !in_ready))
    else $error("served tick did not enter the execute cycle");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (out_valid_r && state_r == S_IDLE))
    else $error("execute cycle produced no result beat");

endmodule
`default_nettype wire

@@ tb/sv/tb_three_level_feedback_queue_scheduler.sv @@
`timescale 1ns / 100ps
module tb_three_level_feedback_queue_scheduler;
  import tlfq_pkg::*;

  localparam int QDEPTH      = DefQueueDepth;
  localparam int SETTLE      = 4;
  localparam int LONG_HOLD   = 80;
  localparam int STALL_LIMIT = 1000;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    status_t             status;
    id_t                 id;
    level_t              level;
    time_t               remaining;
    logic [HELD_W-1:0]   held;
  } sched_result_t;

  // Tracks the three queues and checks each result beat against the oldest
  // outcome still owed.
  class sched_scoreboard;
    slice_t        slice_len[NumLevels];
    slice_t        slice_left[NumLevels];
    id_t           ids[NumLevels][QDEPTH];
    time_t         need_left[NumLevels][QDEPTH];
    int            head[NumLevels];
    int            tail[NumLevels];
    int            count[NumLevels];
    bit            running[NumLevels];
    int            held;
    int            errors;
    sched_result_t expected[$];

    function new();
      slice_len[0] = SLICE_ONE_RST;
      slice_len[1] = SLICE_TWO_RST;
      slice_len[2] = SLICE_THREE_RST;
      for (int lv = 0; lv < NumLevels; lv++) begin
        head[lv]       = 0;
        tail[lv]       = 0;
        count[lv]      = 0;
        running[lv]    = 1'b0;
        slice_left[lv] = slice_len[lv];
      end
      held   = 0;
      errors = 0;
    endfunction

    // A new length only shows up at the next reload of the counter.
    function void set_slice(logic [CIDX_W-1:0] idx, slice_t val);
      case (idx)
        CFG_SLICE_ONE: slice_len[0] = val;
        CFG_SLICE_TWO: slice_len[1] = val;
        CFG_SLICE_THREE: slice_len[2] = val;
        default: ;
      endcase
    endfunction

    function void add_tail(int lv, id_t pid, time_t need);
      ids[lv][tail[lv]]       = pid;
      need_left[lv][tail[lv]] = need;
      tail[lv]                = (tail[lv] + 1) % QDEPTH;
      count[lv]++;
    endfunction

    function void drop_head(int lv);
      head[lv] = (head[lv] + 1) % QDEPTH;
      count[lv]--;
      running[lv] = 1'b0;
    endfunction

    function void note_item(logic act, id_t pid, time_t need);
      sched_result_t r;
      int            lv;
      r.status    = ST_IDLE;
      r.id        = '0;
      r.level     = '0;
      r.remaining = '0;
      lv          = -1;
      if (act == ACT_ADD) begin
        r.id = pid;
        if (held >= QDEPTH) begin
          r.status = ST_REFUSED;
        end else begin
          add_tail(0, pid, need);
          held++;
          r.status    = ST_ADDED;
          r.level     = level_t'(1);
          r.remaining = need;
        end
      end else begin
        // A running head at a higher-numbered level keeps the lower-numbered levels waiting.
        if (count[0] > 0 && !running[1] && !running[2]) lv = 0;
        else if (count[1] > 0 && !running[2]) lv = 1;
        else if (count[2] > 0) lv = 2;
        if (lv >= 0) begin
          r.id        = ids[lv][head[lv]];
          r.remaining = need_left[lv][head[lv]];
          r.level     = level_t'(lv + 1);
          if (slice_left[lv] == 0) begin
            slice_left[lv] = slice_len[lv];
            running[lv]    = 1'b0;
            if (lv < 2) begin
              drop_head(lv);
              add_tail(lv + 1, r.id, r.remaining);
              r.status = ST_DEMOTED;
            end else begin
              r.status = ST_KEPT;
            end
          end else begin
            running[lv] = 1'b1;
            slice_left[lv]--;
            if (r.remaining <= 1) begin
              r.remaining    = '0;
              slice_left[lv] = slice_len[lv];
              drop_head(lv);
              held--;
              r.status = ST_FINISHED;
            end else begin
              r.remaining--;
              need_left[lv][head[lv]] = r.remaining;
              r.status = ST_RAN;
            end
          end
        end
      end
      r.held = HELD_W'(held);
      expected.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [31:0] status, logic [31:0] id, logic [31:0] level,
                               logic [31:0] remaining, logic [31:0] heldc);
      sched_result_t want;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing owed, expected none, got status %0d id %0d",
                 $time, status, id);
      end else begin
        want = expected.pop_front();
        check_field("status", want.status, status);
        check_field("served_id", want.id, id);
        check_field("served_level", want.level, level);
        check_field("remaining_time", want.remaining, remaining);
        check_field("held_count", want.held, heldc);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_action;
  id_t               in_process_id;
  time_t             in_need_time;
  logic              out_valid;
  logic              out_ready;
  status_t           out_status;
  id_t               out_served_id;
  level_t            out_served_level;
  time_t             out_remaining_time;
  logic [HELD_W-1:0] out_held_count;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  slice_t            cfg_wdata;

  sched_scoreboard board;
  bit              steady_end    = 1'b0;
  bit              long_hold_req = 1'b0;
  int              stalled_cycles = 0;

  three_level_feedback_queue_scheduler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_process_id      (in_process_id),
    .in_need_time       (in_need_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_served_id      (out_served_id),
    .out_served_level   (out_served_level),
    .out_remaining_time (out_remaining_time),
    .out_held_count     (out_held_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_item(in_action, in_process_id, in_need_time);
      end
      if (out_valid && out_ready) begin
        board.check_result(out_status, out_served_id, out_served_level,
                           out_remaining_time, out_held_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Result side: random holds, and one long hold on request so a result beat
  // waits on out_ready and the block drops in_ready.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!steady_end && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_item(input logic act, input id_t pid, input time_t need);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_process_id <= pid;
    in_need_time  <= need;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap();
    if (!steady_end && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic put(input logic act, input id_t pid, input time_t need);
    send_item(act, pid, need);
    idle_gap();
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes all three slice lengths, then the unused index, which must not
  // disturb anything.
  task automatic load_slices(input slice_t s1, input slice_t s2, input slice_t s3);
    logic [CIDX_W-1:0] idx[4];
    slice_t            val[4];
    idx[0] = CFG_SLICE_ONE;
    idx[1] = CFG_SLICE_TWO;
    idx[2] = CFG_SLICE_THREE;
    idx[3] = CFG_UNUSED;
    val[0] = s1;
    val[1] = s2;
    val[2] = s3;
    val[3] = slice_t'($urandom);
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      board.set_slice(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input slice_t s1, s2, s3, input int items, add_pct, big_pct,
                           hold_at, pause_at);
    logic  act;
    id_t   pid;
    time_t need;
    int    roll;
    drain(SETTLE);
    load_slices(s1, s2, s3);
    for (int i = 0; i < items; i++) begin
      act  = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_TICK;
      pid  = id_t'($urandom);
      roll = $urandom_range(0, 99);
      // Mostly short jobs, so processes drain and the queues keep moving.
      if (roll < big_pct) need = time_t'($urandom);
      else if (roll < big_pct + 15) need = time_t'($urandom_range(0, 60));
      else need = time_t'($urandom_range(0, 12));
      if (i == hold_at) long_hold_req = 1'b1;
      send_item(act, pid, need);
      if (i == pause_at) drain(0);
      else idle_gap();
    end
  endtask

  initial begin
    board = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_TICK;
    in_process_id <= '0;
    in_need_time  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SLICE_ONE;
    cfg_wdata     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    put(ACT_TICK, 8'h5A, 16'h1234);
    put(ACT_ADD, 8'h00, 16'd0);
    put(ACT_TICK, 8'hC3, 16'hFFFF);
    put(ACT_ADD, 8'hFF, 16'd300);
    put(ACT_ADD, 8'hA5, 16'd1);
    repeat (2) put(ACT_TICK, 8'h00, 16'd0);
    // Fill to capacity, then one add beyond it.
    for (int k = 0; k < 14; k++) begin
      put(ACT_ADD, id_t'(8'h10 + k), time_t'(k));
    end
    put(ACT_ADD, 8'h3C, 16'h8001);
    repeat (3) put(ACT_TICK, 8'hFF, 16'hFFFF);

    run_phase(8'd5, 8'd6, 8'd8, 100, 45, 0, 40, -1);
    run_phase(8'd1, 8'd1, 8'd1, 110, 40, 0, -1, 60);
    run_phase(8'd0, 8'd1, 8'd2, 100, 40, 0, -1, -1);
    run_phase(8'd3, 8'd0, 8'd5, 100, 40, 0, -1, -1);
    run_phase(8'd1, 8'd2, 8'd0, 80, 35, 0, -1, -1);
    run_phase(8'd255, 8'd255, 8'd255, 100, 30, 0, -1, -1);
    run_phase(8'd2, 8'd3, 8'd4, 110, 60, 0, -1, -1);
    run_phase(slice_t'($urandom_range(1, 8)), slice_t'($urandom_range(1, 8)),
              slice_t'($urandom_range(1, 8)), 100, 45, 0, -1, -1);
    run_phase(8'd255, 8'd1, 8'd255, 80, 40, 0, -1, -1);

    // The last stretch runs without idling on either side; the long jobs only
    // come in here since they never leave level three.
    steady_end = 1'b1;
    drain(SETTLE);
    put(ACT_ADD, 8'hFF, 16'hFFFF);
    run_phase(8'd4, 8'd4, 8'd4, 120, 40, 20, -1, -1);
    drain(10);

    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
